[sv/indexed_binary_min_heap_core_macros.svh]
// Assertion macros shared by the indexed binary min-heap RTL.
// Include this header by its bare file name inside a module body.
`ifndef INDEXED_BINARY_MIN_HEAP_CORE_MACROS_SVH
`define INDEXED_BINARY_MIN_HEAP_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IBMH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IBMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ibmh_pkg.sv]
// Shared types and constants for the indexed binary min-heap.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ibmh_pkg;

    // Default sizes handed to the top level parameters.
    localparam int CAPACITY_DEF = 256;
    localparam int ID_COUNT_DEF = 256;
    localparam int KEY_BITS_DEF = 32;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    // Request word.
    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  item_id;
        logic [31:0] item_key;
    } req_word_t;

    // Response word.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_id;
        logic [31:0] out_key;
        logic        out_valid;
        logic [8:0]  entry_count;
        logic [7:0]  top_id;
        logic [31:0] top_key;
        logic        top_valid;
    } rsp_word_t;

endpackage

[sv/ibmh_out_stage.sv]
// Output register for the heap response channel.
// Depends on ibmh_pkg for the response word type.
`timescale 1ns / 1ps

module ibmh_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ibmh_pkg::rsp_word_t word_in,
    output logic               ready,
    output logic               rsp_valid,
    output ibmh_pkg::rsp_word_t rsp_word,
    input  logic               rsp_stall
);
    import ibmh_pkg::*;

    logic      valid_reg;
    rsp_word_t word_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign ready     = !valid_reg || !rsp_stall;
    assign rsp_valid = valid_reg;
    assign rsp_word  = word_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    // Payload holds while stalled.
    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            word_reg <= word_in;
        end
    end

endmodule

[sv/indexed_binary_min_heap_core.sv]
// Indexed binary min-heap priority queue: insert, pop minimum, remove by id and
// update key by id (inserting the id when it is absent), one request word at a
// time. After reset the block clears its id-to-slot table and accepts no word
// meanwhile. Each word walks the heap level by level in sift-up or sift-down,
// reading the slot memory, which has one read and one write port, once per step.
`timescale 1ns / 1ps

module indexed_binary_min_heap_core #(
    parameter int CAPACITY = ibmh_pkg::CAPACITY_DEF,
    parameter int ID_COUNT = ibmh_pkg::ID_COUNT_DEF,
    parameter int KEY_BITS = ibmh_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ibmh_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ibmh_pkg::rsp_word_t rsp_word
);
    import ibmh_pkg::*;
    `include "indexed_binary_min_heap_core_macros.svh"

    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(ID_COUNT);
    localparam int ENT_W  = 8 + KEY_BITS;

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_IDLE  = 16'h0002,
        S_POS   = 16'h0004,
        S_POP_A = 16'h0008,
        S_POP_B = 16'h0010,
        S_RM_A  = 16'h0020,
        S_RM_B  = 16'h0040,
        S_UPD_A = 16'h0080,
        S_UP_RD = 16'h0100,
        S_UP_CMP = 16'h0200,
        S_DN_RD = 16'h0400,
        S_DN_C0 = 16'h0800,
        S_DN_C1 = 16'h1000,
        S_PLACE = 16'h2000,
        S_FIN   = 16'h4000,
        S_TOP   = 16'h8000
    } state_t;

    function automatic logic [IDX_W-1:0] to_idx(input logic [7:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [31:0] key_out(input logic [KEY_BITS-1:0] k);
        logic [63:0] w;
        w = 64'(k);
        return w[31:0];
    endfunction

    function automatic logic [KEY_BITS-1:0] key_in(input logic [31:0] k);
        logic [63:0] w;
        w = 64'(k);
        return w[KEY_BITS-1:0];
    endfunction

    // Control and working registers.
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [1:0]          op_reg, op_next;
    logic [7:0]          id_reg, id_next;
    logic                id_ok_reg, id_ok_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [ENT_W-1:0]    cur_reg, cur_next;
    logic [ENT_W-1:0]    child0_reg, child0_next;
    logic                pick0_reg, pick0_next;
    logic                moved_reg, moved_next;
    logic                try_down_reg, try_down_next;
    logic [1:0]          status_reg, status_next;
    logic [7:0]          oid_reg, oid_next;
    logic [KEY_BITS-1:0] okey_reg, okey_next;
    logic                ovalid_reg, ovalid_next;

    // Memories and their ports.
    logic [ENT_W-1:0]  slot_mem [0:CAPACITY];
    logic [SLOT_W-1:0] pos_mem [0:ID_COUNT-1];
    logic              slot_we, slot_re, pos_we, pos_re;
    logic [SLOT_W-1:0] slot_waddr, slot_raddr;
    logic [ENT_W-1:0]  slot_wdata, slot_rdata_reg;
    logic [IDX_W-1:0]  pos_waddr, pos_raddr;
    logic [SLOT_W-1:0] pos_wdata, pos_rdata_reg;

    // Helpers decoded from the registers.
    logic              accept;
    logic              out_ready, out_load;
    rsp_word_t         rsp_next;
    logic [SLOT_W:0]   c0_addr, c1_addr;
    logic [SLOT_W-1:0] pos_eff;
    logic [KEY_BITS-1:0] rd_key, cur_key, c0_key, pick_key;
    logic [7:0]        rd_id, cur_id;
    logic [31:0]       count32;

    assign accept   = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);

    assign rd_key  = slot_rdata_reg[KEY_BITS-1:0];
    assign rd_id   = slot_rdata_reg[ENT_W-1:KEY_BITS];
    assign cur_key = cur_reg[KEY_BITS-1:0];
    assign cur_id  = cur_reg[ENT_W-1:KEY_BITS];
    assign c0_key  = child0_reg[KEY_BITS-1:0];
    assign pick_key = pick0_reg ? c0_key : cur_key;
    assign c0_addr = {idx_reg, 1'b0};
    assign c1_addr = {idx_reg, 1'b1};
    assign pos_eff = (id_ok_reg && (pos_rdata_reg <= count_reg)) ? pos_rdata_reg : '0;
    assign count32 = 32'(count_reg);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        clr_next      = clr_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        id_ok_next    = id_ok_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        child0_next   = child0_reg;
        pick0_next    = pick0_reg;
        moved_next    = moved_reg;
        try_down_next = try_down_reg;
        status_next   = status_reg;
        oid_next      = oid_reg;
        okey_next     = okey_reg;
        ovalid_next   = ovalid_reg;
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        pos_we     = 1'b0;
        pos_re     = 1'b0;
        slot_waddr = idx_reg;
        slot_raddr = idx_reg;
        slot_wdata = cur_reg;
        pos_waddr  = to_idx(cur_id);
        pos_raddr  = to_idx(req_word.item_id);
        pos_wdata  = idx_reg;
        out_load   = 1'b0;

        unique case (state_reg)
            // Sweep the position table to zero after reset.
            S_CLR:
            begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(ID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            // Take a word and look up its id.
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req_word.operation;
                    id_next     = req_word.item_id;
                    id_ok_next  = 32'(req_word.item_id) < 32'(ID_COUNT);
                    key_next    = key_in(req_word.item_key);
                    status_next = ST_OK;
                    oid_next    = '0;
                    okey_next   = '0;
                    ovalid_next = 1'b0;
                    moved_next  = 1'b0;
                    try_down_next = 1'b0;
                    pos_re      = 1'b1;
                    state_next  = S_POS;
                end
            end
            // Dispatch on the operation with the looked-up position.
            S_POS:
            begin
                cur_next = {id_reg, key_reg};
                unique case (op_reg)
                    OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            slot_re    = 1'b1;
                            slot_raddr = SLOT_W'(1);
                            state_next = S_POP_A;
                        end
                    end
                    OP_REMOVE, OP_UPDATE:
                    begin
                        if (!id_ok_reg)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_FIN;
                        end
                        else if (pos_eff != '0)
                        begin
                            slot_re    = 1'b1;
                            slot_raddr = pos_eff;
                            idx_next   = pos_eff;
                            state_next = (op_reg == OP_REMOVE) ? S_RM_A : S_UPD_A;
                        end
                        else if (op_reg == OP_REMOVE)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_FIN;
                        end
                        else if (count_reg >= SLOT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            idx_next   = count_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    default:
                    begin
                        if (!id_ok_reg)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_FIN;
                        end
                        else if (pos_rdata_reg != '0)
                        begin
                            status_next = ST_PRESENT;
                            state_next  = S_FIN;
                        end
                        else if (count_reg >= SLOT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            idx_next   = count_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                endcase
            end
            // Pop: report the root and fetch the last entry.
            S_POP_A:
            begin
                oid_next    = rd_id;
                okey_next   = rd_key;
                ovalid_next = 1'b1;
                pos_we      = 1'b1;
                pos_waddr   = to_idx(rd_id);
                pos_wdata   = '0;
                count_next  = count_reg - 1'b1;
                idx_next    = SLOT_W'(1);
                if (count_reg == SLOT_W'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = count_reg;
                    state_next = S_POP_B;
                end
            end
            S_POP_B:
            begin
                cur_next   = slot_rdata_reg;
                state_next = S_DN_RD;
            end
            // Remove: report the entry and fetch the last one to fill its slot.
            S_RM_A:
            begin
                oid_next    = id_reg;
                okey_next   = rd_key;
                ovalid_next = 1'b1;
                pos_we      = 1'b1;
                pos_waddr   = to_idx(id_reg);
                pos_wdata   = '0;
                count_next  = count_reg - 1'b1;
                if (idx_reg == count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = count_reg;
                    state_next = S_RM_B;
                end
            end
            S_RM_B:
            begin
                cur_next      = slot_rdata_reg;
                try_down_next = 1'b1;
                state_next    = S_UP_RD;
            end
            // Update: report the old key and pick a direction.
            S_UPD_A:
            begin
                oid_next    = id_reg;
                okey_next   = rd_key;
                ovalid_next = 1'b1;
                if (key_reg < rd_key)
                begin
                    state_next = S_UP_RD;
                end
                else if (key_reg > rd_key)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            // Sift-up: fetch the parent.
            S_UP_RD:
            begin
                if (idx_reg <= SLOT_W'(1))
                begin
                    state_next = (try_down_reg && !moved_reg) ? S_DN_RD : S_PLACE;
                end
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = idx_reg >> 1;
                    state_next = S_UP_CMP;
                end
            end
            // Sift-up: move the parent down unless it is strictly smaller.
            S_UP_CMP:
            begin
                if (rd_key < cur_key)
                begin
                    state_next = (try_down_reg && !moved_reg) ? S_DN_RD : S_PLACE;
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = to_idx(rd_id);
                    idx_next   = idx_reg >> 1;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end
            end
            // Sift-down: fetch the left child if there is one.
            S_DN_RD:
            begin
                if ((idx_reg >= count_reg) || (c0_addr > {1'b0, count_reg}))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = c0_addr[SLOT_W-1:0];
                    state_next = S_DN_C0;
                end
            end
            // Sift-down: judge the left child, then fetch the right one if there is one.
            S_DN_C0:
            begin
                child0_next = slot_rdata_reg;
                pick0_next  = !(cur_key < rd_key);
                if (c1_addr <= {1'b0, count_reg})
                begin
                    slot_re    = 1'b1;
                    slot_raddr = c1_addr[SLOT_W-1:0];
                    state_next = S_DN_C1;
                end
                else if (!(cur_key < rd_key))
                begin
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = to_idx(rd_id);
                    idx_next   = c0_addr[SLOT_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            // Sift-down: choose between the children.
            S_DN_C1:
            begin
                if (rd_key < pick_key)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = to_idx(rd_id);
                    idx_next   = c1_addr[SLOT_W-1:0];
                    state_next = S_DN_RD;
                end
                else if (pick0_reg)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = child0_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = to_idx(child0_reg[ENT_W-1:KEY_BITS]);
                    idx_next   = c0_addr[SLOT_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            // Drop the moving entry into its final slot.
            S_PLACE:
            begin
                slot_we    = 1'b1;
                pos_we     = 1'b1;
                state_next = S_FIN;
            end
            // Fetch the root for the response word.
            S_FIN:
            begin
                slot_re    = 1'b1;
                slot_raddr = SLOT_W'(1);
                state_next = S_TOP;
            end
            // Hand the response word to the output register.
            S_TOP:
            begin
                out_load = out_ready;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response word assembly.
    always_comb
    begin
        rsp_next.status      = status_reg;
        rsp_next.out_id      = oid_reg;
        rsp_next.out_key     = key_out(okey_reg);
        rsp_next.out_valid   = ovalid_reg;
        rsp_next.entry_count = count32[8:0];
        rsp_next.top_valid   = (count_reg != '0);
        rsp_next.top_id      = (count_reg != '0) ? rd_id : 8'd0;
        rsp_next.top_key     = (count_reg != '0) ? key_out(rd_key) : 32'd0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        id_ok_reg    <= id_ok_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        child0_reg   <= child0_next;
        pick0_reg    <= pick0_next;
        moved_reg    <= moved_next;
        try_down_reg <= try_down_next;
        status_reg   <= status_next;
        oid_reg      <= oid_next;
        okey_reg     <= okey_next;
        ovalid_reg   <= ovalid_next;
    end

    // Slot memory.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rdata_reg <= slot_mem[slot_raddr];
        end
    end

    // Position table.
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_re)
        begin
            pos_rdata_reg <= pos_mem[pos_raddr];
        end
    end

    ibmh_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .word_in   (rsp_next),
        .ready     (out_ready),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word),
        .rsp_stall (rsp_stall)
    );

    // The entry count never passes the capacity.
    `IBMH_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= SLOT_W'(CAPACITY), "count over capacity")
    // A returned item only comes with an ok status.
    `IBMH_ASSERT_NOW(a_item_ok, clk, rst_n, rsp_valid && rsp_word.out_valid, rsp_word.status == ST_OK, "item with error status")
    // Handing over a word returns the sequencer to idle.
    `IBMH_ASSERT_NEXT(a_top_idle, clk, rst_n, state_reg == S_TOP && out_ready, state_reg == S_IDLE, "no return to idle")

endmodule
